@@ src/tksd_pkg.sv @@
// Shared constants, codes and cell interface types for the top-k sorted list core.
package tksd_pkg;

  localparam int DEPTH   = 16;
  localparam int SCORE_W = 32;
  localparam int KEY_W   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int LEN_W   = $clog2(DEPTH + 1);
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // register index lives in paddr[2]; byte offset bits are ignored
  localparam logic REG_MAX_ENTRIES = 1'b0;

  typedef struct packed {
    logic load_new;
    logic load_left;
  } tksd_cell_ctrl_t;

  typedef struct packed {
    logic ge;
    logic dup;
  } tksd_cell_flags_t;

endpackage

@@ src/top_k_sorted_insert_dedup_core.sv @@
// Top level: chain of sorted list cells, length/limit control, APB register, result register.
//
//  channel   direction  handshake                 payload
//  command   in         start (busy always low)   kind, score, pattern_key, read_index
//  result    out        done, one cycle           accepted, duplicate, insert_position,
//                                                 entry_count, read_valid, read_score, read_key
//  config    in/out     APB psel/penable/pwrite   max_entries at byte address 0
//
// For every word all cells compare against the new score in parallel and the
// chain shifts in the same edge; the result appears on the cycle after start.
// A new word may be started in every cycle; the result stage cannot be stalled.
// Reset (rst, synchronous) empties the list and clears max_entries; slot contents
// are left as they are and are never shown while not valid.
module top_k_sorted_insert_dedup_core
  import tksd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [SCORE_W-1:0] score,
  input  logic [KEY_W-1:0]          pattern_key,
  input  logic [IDX_W-1:0]          read_index,
  output logic                      done,
  output logic                      accepted,
  output logic                      duplicate,
  output logic [IDX_W-1:0]          insert_position,
  output logic [LEN_W-1:0]          entry_count,
  output logic                      read_valid,
  output logic signed [SCORE_W-1:0] read_score,
  output logic [KEY_W-1:0]          read_key,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  logic [LEN_W-1:0] max_entries;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] length_next;

  logic                      fire;
  logic                      is_ins;
  logic                      is_read;
  logic                      is_clear;
  logic [DEPTH-1:0]          valid_vec;
  logic [DEPTH-1:0]          ge_vec;
  logic [DEPTH-1:0]          dup_vec;
  logic                      dup_any;
  logic [LEN_W-1:0]          pos;
  logic [LEN_W-1:0]          eff_limit;
  logic [LEN_W:0]            len_plus;
  logic [LEN_W-1:0]          grow_len;
  logic                      ins_ok;
  logic                      rd_ok;

  tksd_cell_ctrl_t           ctrl     [DEPTH];
  tksd_cell_flags_t          flags    [DEPTH];
  logic signed [SCORE_W-1:0] cell_score [DEPTH];
  logic [KEY_W-1:0]          cell_key   [DEPTH];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES)) begin
      max_entries <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_ENTRIES) begin
      prdata = {{(DATA_W-LEN_W){1'b0}}, max_entries};
    end
  end

  assign fire     = start && !busy;
  assign is_ins   = fire && (kind == KIND_INSERT);
  assign is_read  = fire && (kind == KIND_READ);
  assign is_clear = fire && (kind == KIND_CLEAR);

  assign eff_limit = ((max_entries == '0) || (max_entries > LEN_W'(DEPTH))) ?
                     LEN_W'(DEPTH) : max_entries;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [SCORE_W-1:0] lsc;
      logic [KEY_W-1:0]          lky;
      logic                      left_ge;

      if (gi == 0) begin : g_head
        assign lsc     = score;
        assign lky     = pattern_key;
        assign left_ge = 1'b1;
      end else begin : g_body
        assign lsc     = cell_score[gi-1];
        assign lky     = cell_key[gi-1];
        assign left_ge = ge_vec[gi-1];
      end

      assign valid_vec[gi] = (LEN_W'(gi) < length);
      assign ge_vec[gi]    = flags[gi].ge;
      assign dup_vec[gi]   = flags[gi].dup;

      // ge cells form a prefix, so the new word lands where ge first drops
      assign ctrl[gi].load_new  = ins_ok && !ge_vec[gi] && left_ge;
      assign ctrl[gi].load_left = ins_ok && !left_ge;

      tksd_cell u_cell (
        .clk        (clk),
        .valid      (valid_vec[gi]),
        .new_score  (score),
        .new_key    (pattern_key),
        .left_score (lsc),
        .left_key   (lky),
        .ctrl       (ctrl[gi]),
        .flags      (flags[gi]),
        .score      (cell_score[gi]),
        .key        (cell_key[gi])
      );
    end
  endgenerate

  assign dup_any = |dup_vec;

  // first cell without ge; all ge gives DEPTH
  always_comb begin
    pos = LEN_W'(DEPTH);
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!ge_vec[i]) begin
        pos = LEN_W'(i);
      end
    end
  end

  assign ins_ok   = is_ins && !dup_any && (pos < eff_limit);
  assign len_plus = {1'b0, length} + (LEN_W+1)'(1);
  assign grow_len = (len_plus > {1'b0, eff_limit}) ? eff_limit : len_plus[LEN_W-1:0];
  assign rd_ok    = is_read && ({1'b0, read_index} < length);

  always_comb begin
    length_next = length;
    priority if (is_clear) begin
      length_next = '0;
    end else if (ins_ok) begin
      length_next = grow_len;
    end else if (is_ins && !dup_any && (length > eff_limit)) begin
      // dropped non-duplicate insert still trims a list left long by a lowered limit
      length_next = eff_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      done   <= 1'b0;
    end else begin
      length <= length_next;
      done   <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted        <= ins_ok;
      duplicate       <= is_ins && dup_any;
      insert_position <= ins_ok ? pos[IDX_W-1:0] : '0;
      entry_count     <= length_next;
      read_valid      <= rd_ok;
      read_score      <= rd_ok ? cell_score[read_index] : '0;
      read_key        <= rd_ok ? cell_key[read_index] : '0;
    end
  end

endmodule

@@ src/tksd_cell.sv @@
// One list slot: holds a score and key, compares against the incoming word, shifts right.
module tksd_cell
  import tksd_pkg::*;
(
  input  logic                      clk,
  input  logic                      valid,
  input  logic signed [SCORE_W-1:0] new_score,
  input  logic        [KEY_W-1:0]   new_key,
  input  logic signed [SCORE_W-1:0] left_score,
  input  logic        [KEY_W-1:0]   left_key,
  input  tksd_cell_ctrl_t           ctrl,
  output tksd_cell_flags_t          flags,
  output logic signed [SCORE_W-1:0] score,
  output logic        [KEY_W-1:0]   key
);

  always_comb begin
    flags.ge  = valid && (score >= new_score);
    flags.dup = valid && (score == new_score) && (key == new_key);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_new) begin
      score <= new_score;
      key   <= new_key;
    end else if (ctrl.load_left) begin
      score <= left_score;
      key   <= left_key;
    end
  end

endmodule

@@ src/tksd_checker.sv @@
// Port-level checks on the top-k list core, bound to the top level.
module tksd_checker
  import tksd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             accepted,
  input logic             duplicate,
  input logic [IDX_W-1:0] insert_position,
  input logic [LEN_W-1:0] entry_count
);

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result word after an accepted command");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result word without a command");

  a_acc_dup_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(accepted && duplicate))
    else $error("insert both stored and rejected");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= LEN_W'(DEPTH)) && (!accepted || entry_count != '0))
    else $error("entry count out of range");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !accepted) |-> (insert_position == '0))
    else $error("position reported for a word that was not stored");

endmodule

bind top_k_sorted_insert_dedup_core tksd_checker u_tksd_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .accepted        (accepted),
  .duplicate       (duplicate),
  .insert_position (insert_position),
  .entry_count     (entry_count)
);
